// ===== hdl/vector3_angle_degrees_macros.svh =====
// Assertion macros for the angle block
`ifndef VECTOR3_ANGLE_DEGREES_MACROS_SVH
`define VECTOR3_ANGLE_DEGREES_MACROS_SVH
`ifndef SYNTHESIS
`define VAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/vad_pkg.sv =====
package vad_pkg;
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FIELD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int CORDIC_STEPS = 23;
    localparam int FRAC_SHIFT = 24;
    localparam int Z_W       = 26;
    localparam int XY_W      = 58;
    localparam logic signed [Z_W-1:0] DEG180_UNITS = 26'sd11796480;
    localparam logic signed [Z_W-1:0] DEG90_UNITS  = 26'sd5898240;

    typedef struct packed {
        logic [FIELD_W-1:0] a_x;
        logic [FIELD_W-1:0] a_y;
        logic [FIELD_W-1:0] a_z;
        logic [FIELD_W-1:0] b_x;
        logic [FIELD_W-1:0] b_y;
        logic [FIELD_W-1:0] b_z;
    } t_vec_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg_q8;
        logic               zero_length;
    } t_angle_out;

    function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
        logic signed [Z_W-1:0] r;
        begin
            case (idx)
                0: r = 26'sd2949120;  1: r = 26'sd1740967; 2: r = 26'sd919879;
                3: r = 26'sd466945;   4: r = 26'sd234379;  5: r = 26'sd117304;
                6: r = 26'sd58666;    7: r = 26'sd29335;   8: r = 26'sd14668;
                9: r = 26'sd7334;     10: r = 26'sd3667;   11: r = 26'sd1833;
                12: r = 26'sd917;     13: r = 26'sd458;    14: r = 26'sd229;
                15: r = 26'sd115;     16: r = 26'sd57;     17: r = 26'sd29;
                18: r = 26'sd14;      19: r = 26'sd7;      20: r = 26'sd4;
                21: r = 26'sd2;       22: r = 26'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== hdl/vad_cordic_stage.sv =====
// One vectoring CORDIC rotation, registered.
module vad_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_zero,
    input  logic signed [vad_pkg::XY_W-1:0]    i_x,
    input  logic signed [vad_pkg::XY_W-1:0]    i_y,
    input  logic signed [vad_pkg::Z_W-1:0]     i_z,
    output logic                               o_valid,
    output logic                               o_zero,
    output logic signed [vad_pkg::XY_W-1:0]    o_x,
    output logic signed [vad_pkg::XY_W-1:0]    o_y,
    output logic signed [vad_pkg::Z_W-1:0]     o_z
);
    import vad_pkg::*;

    logic signed [XY_W-1:0] n_x, n_y, xs, ys, xa, ya;
    logic signed [Z_W-1:0]  n_z;
    logic                   r_valid;
    logic                   r_zero;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;

    always_comb begin
        // symmetric shift: magnitude shifted, sign restored
        xa = i_x[XY_W-1] ? -i_x : i_x;
        ya = i_y[XY_W-1] ? -i_y : i_y;
        xs = i_x[XY_W-1] ? -(xa >>> STEP) : (xa >>> STEP);
        ys = i_y[XY_W-1] ? -(ya >>> STEP) : (ya >>> STEP);
        if (i_y > 0) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + atan_lut(STEP);
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - atan_lut(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_zero <= i_zero;
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_valid = r_valid;
    assign o_zero  = r_zero;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== hdl/vector3_angle_degrees.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------
// command   | in        | i_start / o_busy     | i_vec (t_vec_in)
// result    | out       | o_strobe, one cycle  | o_result (t_angle_out)
//
// One word enters per cycle; o_busy is held low (no back pressure inside).
// The pipeline has 6 front stages (products, sums,
// leading one, normalize, squares, sum of squares), a 32-bit square root in
// 16 stages of 2 bits, 23 CORDIC stages and one output rounding stage.
// Reset clears the valid bits only; the receiver cannot stall.
module vector3_angle_degrees #(
    parameter int COMPONENT_WIDTH = vad_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  vad_pkg::t_vec_in    i_vec,
    output logic                o_strobe,
    output vad_pkg::t_angle_out o_result
);
    import vad_pkg::*;
    `include "vector3_angle_degrees_macros.svh"

    localparam int CW  = COMPONENT_WIDTH;
    localparam int PW  = 2 * CW + 2;      // products and sums, signed
    localparam int MW  = 64;              // squared sum of normalized terms

    // ---------------- stage 1: sign extend, products ----------------
    // Take the low CW bits of each word; wider widths read the word as positive.
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    assign ax = CW'(i_vec.a_x);
    assign ay = CW'(i_vec.a_y);
    assign az = CW'(i_vec.a_z);
    assign bx = CW'(i_vec.b_x);
    assign by = CW'(i_vec.b_y);
    assign bz = CW'(i_vec.b_z);

    logic                    r1_valid, r1_zero;
    logic signed [2*CW-1:0]  r1_p [9];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
        end
        r1_zero <= (ax == '0 && ay == '0 && az == '0) || (bx == '0 && by == '0 && bz == '0);
        r1_p[0] <= ax * bx; r1_p[1] <= ay * by; r1_p[2] <= az * bz;
        r1_p[3] <= ay * bz; r1_p[4] <= az * by;
        r1_p[5] <= az * bx; r1_p[6] <= ax * bz;
        r1_p[7] <= ax * by; r1_p[8] <= ay * bx;
    end

    // ---------------- stage 2: sums, magnitudes ----------------
    logic signed [PW-1:0] dot_c, cx_c, cy_c, cz_c;
    always_comb begin
        dot_c = PW'(r1_p[0]) + PW'(r1_p[1]) + PW'(r1_p[2]);
        cx_c  = PW'(r1_p[3]) - PW'(r1_p[4]);
        cy_c  = PW'(r1_p[5]) - PW'(r1_p[6]);
        cz_c  = PW'(r1_p[7]) - PW'(r1_p[8]);
    end
    logic              r2_valid, r2_zero, r2_dneg;
    logic [PW-1:0]     r2_m [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_zero <= r1_zero;
        r2_dneg <= dot_c[PW-1];
        r2_m[0] <= dot_c[PW-1] ? PW'(-dot_c) : PW'(dot_c);
        r2_m[1] <= cx_c[PW-1] ? PW'(-cx_c) : PW'(cx_c);
        r2_m[2] <= cy_c[PW-1] ? PW'(-cy_c) : PW'(cy_c);
        r2_m[3] <= cz_c[PW-1] ? PW'(-cz_c) : PW'(cz_c);
    end

    // ---------------- stage 3: leading one of the largest ----------------
    logic [PW-1:0] top_or;
    logic [6:0]    lead;
    assign top_or = r2_m[0] | r2_m[1] | r2_m[2] | r2_m[3];
    always_comb begin
        lead = '0;
        for (int k = 0; k < PW; k++) begin
            if (top_or[k]) lead = 7'(k);
        end
    end
    logic          r3_valid, r3_zero, r3_dneg;
    logic [6:0]    r3_lead;
    logic [PW-1:0] r3_m [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_zero <= r2_zero; r3_dneg <= r2_dneg; r3_lead <= lead;
        r3_m <= r2_m;
    end

    // ---------------- stage 4: shift so the top bit lands at 30 ----------
    // The OR of the magnitudes has the same leading bit as the maximum.
    function automatic logic [31:0] norm(input logic [PW-1:0] v, input logic [6:0] ld);
        logic [PW+31:0] w;
        begin
            w = {32'd0, v} << 30;
            return 32'(w >> ld);
        end
    endfunction
    logic        r4_valid, r4_zero, r4_dneg;
    logic [31:0] r4_n [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_zero <= r3_zero; r4_dneg <= r3_dneg;
        for (int k = 0; k < 4; k++) r4_n[k] <= norm(r3_m[k], r3_lead);
    end

    // ---------------- stage 5: squares (three 31x31 products) ----------
    logic        r5_valid, r5_zero, r5_dneg;
    logic [31:0] r5_md;
    logic [61:0] r5_sq [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_zero <= r4_zero; r5_dneg <= r4_dneg; r5_md <= r4_n[0];
        for (int k = 0; k < 3; k++) r5_sq[k] <= 62'(r4_n[k+1][30:0] * r4_n[k+1][30:0]);
    end

    // ---------------- stage 6: sum of squares ----------------
    logic        r6_valid, r6_zero, r6_dneg;
    logic [31:0] r6_md;
    logic [MW-1:0] r6_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_zero <= r5_zero; r6_dneg <= r5_dneg; r6_md <= r5_md;
        r6_sum <= MW'(r5_sq[0]) + MW'(r5_sq[1]) + MW'(r5_sq[2]);
    end

    // ---------------- square root: 16 stages of 2 result bits -----------
    // Restoring digit recurrence; each stage retires 2 bits of the root.
    localparam int SQ_BITS = 2;
    localparam int SQ_ST = 32 / SQ_BITS;
    logic          q_valid [SQ_ST+1];
    logic          q_zero  [SQ_ST+1];
    logic          q_dneg  [SQ_ST+1];
    logic [31:0]   q_md    [SQ_ST+1];
    logic [MW-1:0] q_rem   [SQ_ST+1];
    logic [MW-1:0] q_rad   [SQ_ST+1];
    logic [31:0]   q_root  [SQ_ST+1];
    assign q_valid[0] = r6_valid; assign q_zero[0] = r6_zero;
    assign q_dneg[0] = r6_dneg;   assign q_md[0] = r6_md;
    assign q_rem[0] = '0; assign q_rad[0] = r6_sum; assign q_root[0] = '0;

    for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
        logic [MW-1:0] rem_c, rad_c;
        logic [31:0]   root_c;
        logic [MW-1:0] trial;
        logic          r_v;
        logic          r_z, r_d;
        logic [31:0]   r_md, r_root;
        logic [MW-1:0] r_rem, r_rad;
        always_comb begin
            rem_c = q_rem[g]; rad_c = q_rad[g]; root_c = q_root[g];
            for (int k = 0; k < SQ_BITS; k++) begin
                rem_c  = {rem_c[MW-3:0], rad_c[MW-1:MW-2]};
                rad_c  = {rad_c[MW-3:0], 2'b00};
                trial  = MW'({root_c, 2'b01});
                if (rem_c >= trial) begin
                    rem_c  = rem_c - trial;
                    root_c = {root_c[30:0], 1'b1};
                end else begin
                    root_c = {root_c[30:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= q_valid[g];
            end
            r_z <= q_zero[g]; r_d <= q_dneg[g]; r_md <= q_md[g];
            r_rem <= rem_c; r_rad <= rad_c; r_root <= root_c;
        end
        assign q_valid[g+1] = r_v; assign q_zero[g+1] = r_z;
        assign q_dneg[g+1] = r_d;  assign q_md[g+1] = r_md;
        assign q_rem[g+1] = r_rem; assign q_rad[g+1] = r_rad;
        assign q_root[g+1] = r_root;
    end

    // ---------------- CORDIC start: fold left half plane ----------------
    logic                   c_valid [CORDIC_STEPS+1];
    logic                   c_zero  [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] c_x [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] c_y [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  c_z [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] s_sh, md_sh;
    assign s_sh  = XY_W'({q_root[SQ_ST], 24'd0});
    assign md_sh = XY_W'({q_md[SQ_ST], 24'd0});
    assign c_valid[0] = q_valid[SQ_ST];
    assign c_zero[0]  = q_zero[SQ_ST];
    assign c_x[0] = q_dneg[SQ_ST] ? s_sh : md_sh;
    assign c_y[0] = q_dneg[SQ_ST] ? md_sh : s_sh;
    assign c_z[0] = q_dneg[SQ_ST] ? DEG90_UNITS : '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        vad_cordic_stage #(.STEP(g)) u_stage (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_valid(c_valid[g]), .i_zero(c_zero[g]),
            .i_x(c_x[g]), .i_y(c_y[g]), .i_z(c_z[g]),
            .o_valid(c_valid[g+1]), .o_zero(c_zero[g+1]),
            .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_z(c_z[g+1])
        );
    end

    // ---------------- output: clamp, round, hold zero case ---------------
    logic signed [Z_W-1:0] zf, zcl;
    logic [Z_W-1:0]        zr;
    assign zf = c_z[CORDIC_STEPS];
    always_comb begin
        if (zf < 0) zcl = '0;
        else if (zf > DEG180_UNITS) zcl = DEG180_UNITS;
        else zcl = zf;
        zr = Z_W'(zcl) + Z_W'(128);
    end
    logic       r_strobe;
    t_angle_out r_result;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= c_valid[CORDIC_STEPS];
        end
        r_result.zero_length  <= c_zero[CORDIC_STEPS];
        r_result.angle_deg_q8 <= c_zero[CORDIC_STEPS] ? '0 : zr[ANGLE_W+7:8];
    end

    assign o_busy   = 1'b0;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `VAD_ASSERT_IMPL(a_angle_range, i_clk, i_rst_n, o_strobe, o_result.angle_deg_q8 <= 16'd46080, "angle above 180 degrees")
    `VAD_ASSERT_IMPL(a_zero_angle, i_clk, i_rst_n, o_strobe && o_result.zero_length, o_result.angle_deg_q8 == '0, "zero length with nonzero angle")
    `VAD_ASSERT_NEXT(a_front_valid, i_clk, i_rst_n, r1_valid, r2_valid, "valid lost between stages")
endmodule
